[rtl/csfd_pkg.sv]
// ----------------------------------------------------------------------------
// csfd_pkg
// Types, constants and the CRC-8 helper shared by the sensor frame decoder.
// ----------------------------------------------------------------------------
package csfd_pkg;

   // crc-8 with polynomial 0x31, restarted at 0xff for every data pair
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_MSB  = 8'h80;

   // frame layout: byte position within a frame
   localparam logic [3:0] BYTE_A0    = 4'd0;
   localparam logic [3:0] BYTE_A1    = 4'd1;
   localparam logic [3:0] BYTE_CRC_A = 4'd2;
   localparam logic [3:0] BYTE_B0    = 4'd3;
   localparam logic [3:0] BYTE_B1    = 4'd4;
   localparam logic [3:0] BYTE_CRC_B = 4'd5;
   localparam logic [3:0] IDLE_COUNT = 4'd15;

   localparam logic [3:0] FRAME_LEN_TH  = 4'd6;
   localparam logic [3:0] FRAME_LEN_CO2 = 4'd9;

   // raw codes of the accepted temperature span
   localparam logic [31:0] TEMP_RAW_MIN = 32'd1873;
   localparam logic [31:0] TEMP_RAW_MAX = 32'd63662;

   // register reset values
   localparam logic [15:0] PPM_MIN_RESET = 16'd300;
   localparam logic [15:0] PPM_MAX_RESET = 16'd10000;

   // register file
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_SENSOR_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PPM_MIN     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PPM_MAX     = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_CRC_ERR   = 2'd1,
      STATUS_RANGE_ERR = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
   } req_payload_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] value_a;
      logic [15:0] value_b;
   } rsp_payload_type;

   typedef struct packed {
      logic        sensor_mode;
      logic [15:0] ppm_min;
      logic [15:0] ppm_max;
   } cfg_type;

   // byte-wide crc update, msb first
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_MSB) != 8'h00) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

[rtl/csfd_csr.sv]
// ----------------------------------------------------------------------------
// csfd_csr
// Configuration registers: frame mode and the co2 acceptance window.
// ----------------------------------------------------------------------------
module csfd_csr import csfd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // writes are always accepted
   assign csr_ready = 1'b1;

   // register decode, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SENSOR_MODE: cfg_in.sensor_mode = csr_data[0];
            CSR_PPM_MIN:     cfg_in.ppm_min     = csr_data;
            CSR_PPM_MAX:     cfg_in.ppm_max     = csr_data;
            default:         cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sensor_mode <= 1'b0;
         cfg_ff.ppm_min     <= PPM_MIN_RESET;
         cfg_ff.ppm_max     <= PPM_MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/csfd_frame_track.sv]
// ----------------------------------------------------------------------------
// csfd_frame_track
// Frame state: byte position, running crc, error flag and word assembly.
// Produces one result on the last byte of a frame.
// ----------------------------------------------------------------------------
module csfd_frame_track import csfd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            step_valid,
   input  req_payload_type step_payload,
   input  cfg_type         cfg,
   output logic            result_valid,
   output rsp_payload_type result_payload
);

   logic [3:0]  byte_count_ff,  byte_count_in;
   logic [7:0]  running_crc_ff, running_crc_in;
   logic        crc_failed_ff,  crc_failed_in;
   logic [31:0] word_a_ff,      word_a_in;
   logic [15:0] word_b_ff,      word_b_in;

   logic [3:0]  idx;
   logic [3:0]  frame_len;
   logic [7:0]  rx;
   logic        co2;
   logic        in_range;

   assign rx        = step_payload.rx_byte;
   assign co2       = cfg.sensor_mode;
   assign frame_len = co2 ? FRAME_LEN_CO2 : FRAME_LEN_TH;

   // next frame state for one byte transfer
   always_comb begin
      byte_count_in  = byte_count_ff;
      running_crc_in = running_crc_ff;
      crc_failed_in  = crc_failed_ff;
      word_a_in      = word_a_ff;
      word_b_in      = word_b_ff;
      result_valid   = 1'b0;
      idx            = byte_count_ff;

      if (step_valid) begin
         // frame start restarts the count and clears the words
         if (step_payload.frame_start) begin
            idx           = BYTE_A0;
            byte_count_in = BYTE_A0;
            crc_failed_in = 1'b0;
            word_a_in     = '0;
            word_b_in     = '0;
         end

         if (idx < frame_len) begin
            // crc per data pair
            case (idx) inside
               BYTE_A0, BYTE_B0:       running_crc_in = crc8_update(CRC_INIT, rx);
               BYTE_A1, BYTE_B1:       running_crc_in = crc8_update(running_crc_ff, rx);
               BYTE_CRC_A, BYTE_CRC_B: begin
                  if (running_crc_ff != rx) begin
                     crc_failed_in = 1'b1;
                  end
               end
               default: ;
            endcase

            // word assembly
            if (idx == BYTE_A0 || idx == BYTE_A1 ||
                ((idx == BYTE_B0 || idx == BYTE_B1) && co2)) begin
               word_a_in = {word_a_in[23:0], rx};
            end else if (idx == BYTE_B0 || idx == BYTE_B1) begin
               word_b_in = {word_b_in[7:0], rx};
            end

            // advance or close the frame
            if (idx == frame_len - 4'd1) begin
               byte_count_in = IDLE_COUNT;
               result_valid  = 1'b1;
            end else begin
               byte_count_in = idx + 4'd1;
            end
         end
      end
   end

   // range check on the assembled first word
   always_comb begin
      if (co2) begin
         in_range = (word_a_in >= {16'h0000, cfg.ppm_min}) &&
                    (word_a_in <= {16'h0000, cfg.ppm_max});
      end else begin
         in_range = (word_a_in >= TEMP_RAW_MIN) && (word_a_in <= TEMP_RAW_MAX);
      end
   end

   // result fields, crc error takes priority
   always_comb begin
      if (crc_failed_in) begin
         result_payload.status = STATUS_CRC_ERR;
      end else if (!in_range) begin
         result_payload.status = STATUS_RANGE_ERR;
      end else begin
         result_payload.status = STATUS_OK;
      end
      result_payload.value_a = word_a_in;
      result_payload.value_b = co2 ? 16'h0000 : word_b_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff  <= BYTE_A0;
         running_crc_ff <= CRC_INIT;
         crc_failed_ff  <= 1'b0;
         word_a_ff      <= '0;
         word_b_ff      <= '0;
      end else begin
         byte_count_ff  <= byte_count_in;
         running_crc_ff <= running_crc_in;
         crc_failed_ff  <= crc_failed_in;
         word_a_ff      <= word_a_in;
         word_b_ff      <= word_b_in;
      end
   end

endmodule

[rtl/crc_checked_sensor_frame_decoder_core.sv]
// ----------------------------------------------------------------------------
// crc_checked_sensor_frame_decoder_core
// Checks i2c sensor response frames byte by byte and reports one status
// per frame.
//
// Input channel req_*: one received byte per transfer, frame_start marks
// byte 0 of a frame. Six-byte temperature/humidity frames or nine-byte
// co2 frames, each data pair followed by a crc-8 (poly 0x31, init 0xff).
// Result channel rsp_*: on the last byte of a frame one transfer with
// status (ok, crc error, out of range) and the assembled words.
// Other bytes give no result; bytes after a frame end are dropped until
// the next frame_start.
// Register port csr_*: index 0 mode, 1 ppm_min, 2 ppm_max; writes are
// always accepted. Write only while the block is idle.
// Path: a byte sits in the input register and is decoded into the result
// register, from which the result is offered on rsp_*.
// Throughput: one byte per cycle while no result waits for rsp_ready,
// set by the combinational crc update.
// Reset clears frame state, both valid flags and restores register defaults.
// When a result waits and rsp_ready is low the result register holds, the
// input register fills, and req_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module crc_checked_sensor_frame_decoder_core import csfd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type         cfg;
   logic            in_valid_ff, in_valid_in;
   req_payload_type in_data_ff;
   logic            advance;
   logic            result_valid;
   rsp_payload_type result_payload;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff;

   csfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // decode a byte when the result register is free or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // input register
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_payload;
      end
   end

   csfd_frame_track u_frame_track (
      .clock          (clock),
      .reset          (reset),
      .step_valid     (advance),
      .step_payload   (in_data_ff),
      .cfg            (cfg),
      .result_valid   (result_valid),
      .result_payload (result_payload)
   );

   // result register
   always_comb begin
      if (advance) begin
         rsp_valid_in = result_valid;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result_valid) begin
         rsp_data_ff <= result_payload;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule
